>>> hdl/omsp_pkg.sv
// Shared types, constants and decode helpers for the order message stream parser.
// No dependencies; every other file of the block imports this package.
package omsp_pkg;

    localparam int NUM_STREAMS = 16;
    localparam int STREAM_W    = 4;
    localparam int NUM_KINDS   = 5;
    localparam int KIND_W      = 3;
    localparam int OFFSET_W    = 7;
    localparam int COUNT_W     = 32;
    localparam int SHARES_W    = 32;
    localparam int TOTAL_W     = 48;

    // Type counter RAM: one entry per stream and kind code, addressed {stream, kind}.
    localparam int COUNT_AW    = STREAM_W + KIND_W;
    localparam int COUNT_DEPTH = 1 << COUNT_AW;

    localparam logic [OFFSET_W-1:0] TYPE_OFFSET = 7'd3;
    localparam logic [OFFSET_W-1:0] SHARE_FIRST = 7'd26;
    localparam logic [OFFSET_W-1:0] SHARE_LAST  = 7'd29;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        KIND_A = 3'd0,
        KIND_S = 3'd1,
        KIND_U = 3'd2,
        KIND_C = 3'd3,
        KIND_E = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_TYPE     = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_UNKNOWN  = 2'd3
    } event_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [7:0]          data_byte;
    } item_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream_out;
        event_t              event_res;
        kind_t               kind;
        logic [COUNT_W-1:0]  kind_count;
        logic [SHARES_W-1:0] message_shares;
        logic [TOTAL_W-1:0]  shares_total;
    } result_t;

    typedef struct packed {
        logic  known;
        kind_t kind;
    } decode_t;

    // ASCII type byte to kind code.
    function automatic decode_t decode_kind(input logic [7:0] b);
        decode_t d;
        d.known = 1'b1;
        d.kind  = KIND_A;
        case (b)
            8'h41:   d.kind = KIND_A;
            8'h53:   d.kind = KIND_S;
            8'h55:   d.kind = KIND_U;
            8'h43:   d.kind = KIND_C;
            8'h45:   d.kind = KIND_E;
            default: d.known = 1'b0;
        endcase
        return d;
    endfunction

    // Total message length in bytes for each kind.
    function automatic logic [OFFSET_W-1:0] kind_len(input kind_t k);
        logic [OFFSET_W-1:0] len;
        case (k)
            KIND_A:  len = 7'd68;
            KIND_S:  len = 7'd13;
            KIND_U:  len = 7'd82;
            KIND_C:  len = 7'd31;
            KIND_E:  len = 7'd43;
            default: len = 7'd68;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/omsp_in_stage.sv
// Input register of the order message stream parser: holds one accepted request.
// Depends on omsp_pkg for the item type.
module omsp_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [omsp_pkg::STREAM_W-1:0] s_stream,
    input  logic [7:0]                    s_data_byte,
    input  logic                          take,
    output logic                          item_valid,
    output omsp_pkg::item_t               item
);
    import omsp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Room when empty or when the held request leaves this cycle.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.stream    <= s_stream;
            item_reg.data_byte <= s_data_byte;
        end
    end

endmodule

>>> hdl/omsp_core.sv
// Per-stream parse state, the type counter RAM and the single-pass update logic of one byte.
// Depends on omsp_pkg for types, constants, type decode and message lengths.
module omsp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [omsp_pkg::STREAM_W-1:0] rd_stream,
    input  logic [7:0]                    rd_data_byte,
    input  logic                          take,
    input  omsp_pkg::item_t               item,
    output omsp_pkg::result_t             result
);
    import omsp_pkg::*;

    logic [OFFSET_W-1:0] offset_reg   [NUM_STREAMS];
    kind_t               kind_reg     [NUM_STREAMS];
    logic [SHARES_W-1:0] shares_reg   [NUM_STREAMS];
    logic [COUNT_W-1:0]  kind_cnt_reg [NUM_STREAMS];
    logic [TOTAL_W-1:0]  total_reg    [NUM_STREAMS];

    // Type counters live in a RAM; a valid flag per entry makes unwritten entries read zero.
    logic [COUNT_W-1:0]  count_ram     [COUNT_DEPTH];
    logic                count_vld_reg [COUNT_DEPTH];
    logic [COUNT_W-1:0]  count_rd_reg;
    logic                count_rd_vld_reg;

    logic [STREAM_W-1:0] s;
    logic                stream_ok;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] off_inc;
    decode_t             dec;
    decode_t             rd_dec;
    logic [COUNT_AW-1:0] rd_addr;
    logic [COUNT_AW-1:0] wr_addr;
    logic                count_wr;
    kind_t               cur_kind;
    logic [COUNT_W-1:0]  cnt_type;
    logic [COUNT_W-1:0]  cnt_kind;
    logic [SHARES_W-1:0] shares_cur;
    logic [TOTAL_W-1:0]  total_cur;
    logic [TOTAL_W:0]    total_sum;

    logic [OFFSET_W-1:0] offset_next;
    kind_t               kind_next;
    logic [SHARES_W-1:0] shares_next;
    logic [COUNT_W-1:0]  count_next;
    logic                count_we;
    logic [TOTAL_W-1:0]  total_next;
    logic                kind_we;

    assign s         = item.stream;
    assign stream_ok = (32'(s) < NUM_STREAMS);
    assign off       = offset_reg[s];
    assign off_inc   = off + 7'd1;
    assign dec       = decode_kind(item.data_byte);
    assign cur_kind  = (kind_reg[s] == KIND_E || kind_reg[s] < KIND_E) ? kind_reg[s] : KIND_A;
    // The counter of the decoded type is fetched when the byte is accepted, so its data
    // is ready while the byte sits in the input register. Only a type byte uses it.
    assign rd_dec    = decode_kind(rd_data_byte);
    assign rd_addr   = {rd_stream, rd_dec.kind};
    assign wr_addr   = {s, dec.kind};
    assign count_wr  = take && count_we;
    assign cnt_type  = count_rd_vld_reg ? count_rd_reg : '0;
    // The count of the kind in progress is kept per stream for the completing byte.
    assign cnt_kind  = kind_cnt_reg[s];
    assign shares_cur = shares_reg[s];
    assign total_cur = total_reg[s];

    always_comb begin
        offset_next = off;
        kind_next   = cur_kind;
        kind_we     = 1'b0;
        shares_next = shares_cur;
        count_next  = cnt_type;
        count_we    = 1'b0;
        total_next  = total_cur;
        total_sum   = {1'b0, total_cur} + {{(TOTAL_W-SHARES_W+1){1'b0}}, shares_next};

        result.stream_out     = s;
        result.event_res      = EV_NONE;
        result.kind           = KIND_A;
        result.kind_count     = '0;
        result.message_shares = '0;
        result.shares_total   = '0;

        if (stream_ok) begin
            if (off < TYPE_OFFSET) begin
                offset_next = off_inc;
            end else if (off == TYPE_OFFSET) begin
                if (!dec.known) begin
                    result.event_res = EV_UNKNOWN;
                    offset_next      = '0;
                end else begin
                    kind_next   = dec.kind;
                    kind_we     = 1'b1;
                    shares_next = '0;
                    count_next  = (cnt_type == COUNT_MAX) ? cnt_type : cnt_type + 32'd1;
                    count_we    = 1'b1;
                    offset_next = off_inc;
                    result.event_res  = EV_TYPE;
                    result.kind       = dec.kind;
                    result.kind_count = count_next;
                end
            end else begin
                if (cur_kind == KIND_E && off inside {[SHARE_FIRST:SHARE_LAST]}) begin
                    shares_next = {shares_cur[SHARES_W-9:0], item.data_byte};
                    if (off == SHARE_LAST) begin
                        total_sum  = {1'b0, total_cur}
                                   + {{(TOTAL_W-SHARES_W+1){1'b0}}, shares_next};
                        total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    end
                end
                if (off_inc >= kind_len(cur_kind)) begin
                    result.event_res  = EV_COMPLETE;
                    result.kind       = cur_kind;
                    result.kind_count = cnt_kind;
                    result.message_shares = (cur_kind == KIND_E) ? shares_next : '0;
                    offset_next = '0;
                end else begin
                    offset_next = off_inc;
                end
            end
            result.shares_total = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                offset_reg[i]   <= '0;
                kind_reg[i]     <= KIND_A;
                shares_reg[i]   <= '0;
                kind_cnt_reg[i] <= '0;
                total_reg[i]    <= '0;
            end
        end else if (take && stream_ok) begin
            offset_reg[s] <= offset_next;
            shares_reg[s] <= shares_next;
            total_reg[s]  <= total_next;
            if (kind_we) begin
                kind_reg[s]     <= kind_next;
                kind_cnt_reg[s] <= count_next;
            end
        end
    end

    // Counter RAM: one write per recognized type byte, one read per accepted request.
    // A write to the entry being read in the same cycle is passed straight through.
    always_ff @(posedge aclk) begin
        if (count_wr) begin
            count_ram[wr_addr] <= count_next;
        end
        if (rd_en) begin
            if (count_wr && wr_addr == rd_addr) begin
                count_rd_reg <= count_next;
            end else begin
                count_rd_reg <= count_ram[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COUNT_DEPTH; i++) begin
                count_vld_reg[i] <= 1'b0;
            end
            count_rd_vld_reg <= 1'b0;
        end else begin
            if (count_wr) begin
                count_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                count_rd_vld_reg <= (count_wr && wr_addr == rd_addr) || count_vld_reg[rd_addr];
            end
        end
    end

endmodule

>>> hdl/order_message_stream_parser.sv
// Top level of the order message stream parser: input stage, parse core, result register.
// Depends on omsp_pkg, omsp_in_stage and omsp_core.
//
// Usage: the s_ channel carries one payload byte per request, tagged with its stream
// index (0 to 15) and a packet_end flag. Packet boundaries do not affect parsing, so
// a message may be split across packets; the flag is accepted and otherwise ignored.
// For every accepted byte the m_ channel delivers exactly one result request, in order.
// The result names the stream, an event (none, type recognized, message completed,
// unknown type), the message kind with that stream's saturating count of it, the
// share count of a completed E message, and the stream's saturating share total.
// Path: a byte accepted into the input register is parsed from there, and its result is
// loaded into the result register, which drives m_valid.
// Throughput: one byte per cycle, sustained while m_ready stays high, including bytes of
// the same stream in consecutive cycles; the per-stream state is updated at the same edge
// that loads the result register, so the following byte always sees the new state. The
// type counter RAM is read at the accept edge, so its data is ready while the byte is parsed.
// Reset (aresetn low, synchronous) empties both registers and clears every stream's
// offset, kind, share bytes and share total at once; the type counter RAM entries are
// flagged empty at the same time and read as zero until written, so no clearing pass.
// When the receiver holds m_ready low, the result register keeps its request, the
// input register still takes one more byte, and then s_ready drops until the result
// leaves; nothing is lost or repeated.
module order_message_stream_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [omsp_pkg::STREAM_W-1:0] s_stream,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_packet_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [omsp_pkg::STREAM_W-1:0] m_stream_out,
    output logic [1:0]                    m_event_res,
    output logic [2:0]                    m_kind,
    output logic [omsp_pkg::COUNT_W-1:0]  m_kind_count,
    output logic [omsp_pkg::SHARES_W-1:0] m_message_shares,
    output logic [omsp_pkg::TOTAL_W-1:0]  m_shares_total
);
    import omsp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    accept;
    logic    take;
    logic    load;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;

    // The result register can load when it is empty or its request is leaving.
    assign load   = !out_valid_reg || m_ready;
    assign take   = item_valid && load;
    assign accept = s_valid && s_ready;

    omsp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_stream    (s_stream),
        .s_data_byte (s_data_byte),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    omsp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (accept),
        .rd_stream    (s_stream),
        .rd_data_byte (s_data_byte),
        .take         (take),
        .item         (item),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result;
        end
    end

    // The packet end flag is part of the request but has no effect on parsing.
    assign m_valid          = out_valid_reg;
    assign m_stream_out     = result_reg.stream_out;
    assign m_event_res      = result_reg.event_res;
    assign m_kind           = result_reg.kind;
    assign m_kind_count     = result_reg.kind_count;
    assign m_message_shares = result_reg.message_shares;
    assign m_shares_total   = result_reg.shares_total;

    // A byte without a recognized or completed message carries no kind or count.
    a_kind_only_with_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_NONE || m_event_res == EV_UNKNOWN)
        |-> m_kind == KIND_A && m_kind_count == '0)
        else $error("kind or count reported without a message event");

    // Share counts appear only on completion of an E message.
    a_shares_only_on_e: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_shares != '0
        |-> m_event_res == EV_COMPLETE && m_kind == KIND_E)
        else $error("message shares outside a completed E message");

    // A recognized type has just been counted, so its count is at least one.
    a_type_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_TYPE |-> m_kind_count != '0)
        else $error("recognized type with a zero count");

    // Back pressure at the input only arises from a full input register.
    a_ready_low_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> item_valid && out_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

endmodule
